### sv/toy_feistel_block_cipher_64_core_assert.svh
// Assertion macros shared by the cipher core.
`ifndef TOY_FEISTEL_BLOCK_CIPHER_64_CORE_ASSERT_SVH
`define TOY_FEISTEL_BLOCK_CIPHER_64_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define TFBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cipher core assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define TFBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cipher core assertion failed");

`else

`define TFBC_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define TFBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### sv/tfbc_pkg.sv
package tfbc_pkg;

    localparam int BLK_W      = 64;
    localparam int WORD_W     = 16;
    localparam int KEY_W      = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 1'b1;

    // Mode register codes
    localparam logic MODE_ENC = 1'b0;
    localparam logic MODE_DEC = 1'b1;

    // Block viewed as four words, word 0 in bits 15:0
    typedef logic [3:0][WORD_W-1:0] t_words;

    function automatic logic [7:0] rol8_2(logic [7:0] v);
        return {v[5:0], v[7:6]};
    endfunction

    // Byte mix: lo = b ^ ~a, hi = b ^ rotl(lo, 2)
    function automatic logic [WORD_W-1:0] mix_fwd(logic [WORD_W-1:0] x);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = x[15:8] ^ ~x[7:0];
        hi = x[15:8] ^ rol8_2(lo);
        return {hi, lo};
    endfunction

    // Inverse byte mix
    function automatic logic [WORD_W-1:0] mix_inv(logic [WORD_W-1:0] x);
        logic [7:0] b;
        logic [7:0] a;
        b = x[15:8] ^ rol8_2(x[7:0]);
        a = ~(b ^ x[7:0]);
        return {b, a};
    endfunction

    // Round key: even bits of the low half of the key rotated right by 2r
    function automatic logic [WORD_W-1:0] sub_key(logic [KEY_W-1:0] key, int unsigned r);
        logic [5:0]         amt;
        logic [2*KEY_W-1:0] dbl;
        logic [WORD_W-1:0]  k;
        amt = 6'(2 * r);
        dbl = {key, key} >> amt;
        for (int i = 0; i < WORD_W; i++) begin
            k[i] = dbl[2*i];
        end
        return k;
    endfunction

endpackage

### sv/tfbc_in_if.sv
interface tfbc_in_if;
    logic                       valid;
    logic                       ready;
    logic [tfbc_pkg::BLK_W-1:0] block_in;

    modport source (output valid, output block_in, input ready);
    modport sink   (input valid, input block_in, output ready);
endinterface

### sv/tfbc_out_if.sv
interface tfbc_out_if;
    logic                       valid;
    logic                       ready;
    logic [tfbc_pkg::BLK_W-1:0] block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

### sv/tfbc_round.sv
module tfbc_round #(
    parameter bit IS_LAST = 1'b0
) (
    input  logic                        i_decrypt,
    input  logic [tfbc_pkg::WORD_W-1:0] i_key,
    input  tfbc_pkg::t_words            i_w,
    output tfbc_pkg::t_words            o_w
);

    tfbc_pkg::t_words enc;
    tfbc_pkg::t_words dec;
    tfbc_pkg::t_words enc_p;
    tfbc_pkg::t_words dec_p;

    // Encrypt round: mix w1, key into w3, fold new w3 into w2
    always_comb begin
        enc[0] = i_w[0];
        enc[1] = tfbc_pkg::mix_fwd(i_w[1]);
        enc[3] = i_w[3] ^ i_key;
        enc[2] = i_w[2] ^ enc[3];
    end

    // Decrypt round: undo the encrypt round
    always_comb begin
        dec[0] = i_w[0];
        dec[1] = tfbc_pkg::mix_inv(i_w[1]);
        dec[2] = i_w[2] ^ i_w[3];
        dec[3] = i_w[3] ^ i_key;
    end

    // Word permutation between rounds and its inverse
    always_comb begin
        if (IS_LAST) begin
            enc_p = enc;
            dec_p = dec;
        end else begin
            enc_p = {enc[1], enc[3], enc[0], enc[2]};
            dec_p = {dec[2], dec[0], dec[3], dec[1]};
        end
    end

    assign o_w = (i_decrypt == tfbc_pkg::MODE_DEC) ? dec_p : enc_p;

endmodule

### sv/toy_feistel_block_cipher_64_core.sv
// Channel  | Dir | Payload            | Handshake
// ---------+-----+--------------------+-----------------------------
// i_in     | in  | block_in  [63:0]   | valid/ready, accept on both
// o_out    | out | block_out [63:0]   | valid/ready, accept on both
// i_cfg_*  | in  | idx [0], data [63:0]| write when i_cfg_we
//
// One block per cycle while o_out.ready stays high; an accepted block moves from the
// input register via ROUNDS XOR/mix rounds to the result register that drives o_out.
// Synchronous active-low reset clears both valid flags, key and mode.
// A stalled output holds its block; the input register still drains into an
// empty result register, so i_in.ready drops only when both are full.
module toy_feistel_block_cipher_64_core #(
    parameter int ROUNDS = 3
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tfbc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [tfbc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    tfbc_in_if.sink                         i_in,
    tfbc_out_if.source                      o_out
);

`include "toy_feistel_block_cipher_64_core_assert.svh"

    logic [tfbc_pkg::KEY_W-1:0] r_key;
    logic                       r_mode;

    logic                       r_v1;
    tfbc_pkg::t_words           r_d1;
    logic                       r_v2;
    tfbc_pkg::t_words           r_d2;

    logic                       adv1;
    logic                       acc_in;
    tfbc_pkg::t_words           w_chain [ROUNDS+1];
    logic [tfbc_pkg::WORD_W-1:0] w_key  [ROUNDS];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key  <= '0;
            r_mode <= tfbc_pkg::MODE_ENC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tfbc_pkg::CFG_KEY:  r_key  <= i_cfg_data;
                tfbc_pkg::CFG_MODE: r_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Handshake: stage 1 moves when stage 2 is empty or being drained
    assign adv1       = !r_v2 || o_out.ready;
    assign i_in.ready = !r_v1 || adv1;
    assign acc_in     = i_in.valid && i_in.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (i_in.ready) begin
            r_v1 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_in) begin
            r_d1 <= i_in.block_in;
        end
    end

    // Round chain; decrypt walks the round keys in reverse
    assign w_chain[0] = r_d1;

    for (genvar j = 0; j < ROUNDS; j++) begin : g_round
        localparam int unsigned ENC_R = j;
        localparam int unsigned DEC_R = ROUNDS - 1 - j;

        assign w_key[j] = (r_mode == tfbc_pkg::MODE_DEC)
                        ? tfbc_pkg::sub_key(r_key, DEC_R)
                        : tfbc_pkg::sub_key(r_key, ENC_R);

        tfbc_round #(
            .IS_LAST (j == ROUNDS - 1)
        ) u_round (
            .i_decrypt (r_mode),
            .i_key     (w_key[j]),
            .i_w       (w_chain[j]),
            .o_w       (w_chain[j+1])
        );
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (adv1) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && r_v1) begin
            r_d2 <= w_chain[ROUNDS];
        end
    end

    assign o_out.valid     = r_v2;
    assign o_out.block_out = r_d2;

    // Checks
    `TFBC_ASSERT_NEXT(a_in_fills_s1, i_clk, i_rst_n, acc_in, r_v1)
    `TFBC_ASSERT_NEXT(a_s1_fills_s2, i_clk, i_rst_n, r_v1 && adv1, r_v2)
    `TFBC_ASSERT_NEXT(a_out_holds, i_clk, i_rst_n, r_v2 && !o_out.ready,
                      r_v2 && $stable(r_d2))
    `TFBC_ASSERT_NOW(a_ready_if_not_full, i_clk, i_rst_n, !(r_v1 && r_v2), i_in.ready)

endmodule
